@@ src/mse_pkg.sv @@
// Shared constants and types for the MIPS subset execute core.
// Holds opcode and function codes, status codes and data memory sizing.
// No dependencies.
package mse_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_AW = $clog2(NUM_REGS);

    localparam int DMEM_WORDS = 1024;
    localparam int DMEM_AW = $clog2(DMEM_WORDS);

    // The word index is formed from the 14 upper immediate bits plus a constant
    // offset for negative immediates, then reduced modulo the memory depth.
    localparam int MIDX_W = $clog2(16384 + DMEM_WORDS);
    localparam int NEG_OFS = 32'h3FFF_C000 % DMEM_WORDS;
    localparam int RECIP = (2 ** MIDX_W) / DMEM_WORDS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W = MIDX_W + RECIP_W;

    localparam logic [5:0] OPC_SPECIAL = 6'd0;
    localparam logic [5:0] OPC_BEQ = 6'd4;
    localparam logic [5:0] OPC_BNE = 6'd5;
    localparam logic [5:0] OPC_ADDIU = 6'd9;
    localparam logic [5:0] OPC_LW = 6'd35;
    localparam logic [5:0] OPC_SW = 6'd43;
    localparam logic [5:0] OPC_END = 6'd60;

    localparam logic [5:0] FN_NOP = 6'd0;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SLT = 6'd42;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NOT_IMPL = 2'd1,
        ST_END = 2'd2
    } status_t;

endpackage

@@ src/mips_subset_execute_core.sv @@
// Top level of the MIPS subset execute core.
// Holds the register file, data memory, program counter and the pipeline.
// Depends on mse_pkg.
//
// One instruction word enters as a beat on the input channel (in_valid,
// in_stall) and one result beat leaves on the output channel (out_valid,
// out_stall) for every instruction, in order.
// The pipeline has three registers: an address stage that reduces the load
// and store address, an execute stage whose register file and data memory
// reads are registered, and the result register. A result is offered once
// its instruction has passed the address and execute stages; throughput is
// one instruction per cycle while out_stall is low. The last result written
// to the register file and to memory is forwarded into the execute stage.
// After reset the data memory is cleared one word per cycle, all DMEM_WORDS
// (1024) words, with in_stall high meanwhile. The register file is cleared
// at once by its valid bits. The program counter resets to zero; cfg_wr_en
// loads it with cfg_wr_data unless an instruction leaves the execute stage.
// When out_stall is high the result beat is held and the earlier stages fill
// up; in_stall rises once the address stage can no longer advance.
module mips_subset_execute_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instruction_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [31:0]        next_pc,
    output logic               reg_written,
    output logic [4:0]         reg_index,
    output logic signed [31:0] reg_value,
    output logic               mem_written
);
    import mse_pkg::*;

    localparam logic [DMEM_AW-1:0] DMEM_LAST = DMEM_AW'(DMEM_WORDS - 1);
    localparam logic [MIDX_W-1:0] DEPTH_M = MIDX_W'(DMEM_WORDS);

    logic [31:0] rf_mem [NUM_REGS];
    logic [31:0] dmem_mem [DMEM_WORDS];

    logic [NUM_REGS-1:0] rf_valid_reg;
    logic                clearing_reg;
    logic [DMEM_AW-1:0]  clr_addr_reg;

    logic                s0_valid_reg;
    logic [31:0]         s0_instr_reg;
    logic [MIDX_W-1:0]   s0_v_reg;
    logic [RECIP_W-1:0]  s0_q_reg;

    logic                s1_valid_reg;
    logic [31:0]         s1_instr_reg;
    logic [DMEM_AW-1:0]  s1_midx_reg;
    logic [31:0]         rs_data_reg;
    logic [31:0]         rt_data_reg;
    logic                rs_vld_reg;
    logic                rt_vld_reg;
    logic [31:0]         dmem_rd_reg;

    logic                fwd_rf_valid_reg;
    logic [REG_AW-1:0]   fwd_rf_idx_reg;
    logic [31:0]         fwd_rf_val_reg;
    logic                fwd_mem_valid_reg;
    logic [DMEM_AW-1:0]  fwd_mem_idx_reg;
    logic [31:0]         fwd_mem_val_reg;

    logic [31:0]         pc_reg;
    logic                halted_reg;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [31:0]         next_pc_reg;
    logic                reg_written_reg;
    logic [4:0]          reg_index_reg;
    logic [31:0]         reg_value_reg;
    logic                mem_written_reg;

    logic                in_accept;
    logic                s0_adv;
    logic                s1_adv;

    logic [MIDX_W-1:0]   in_v;
    logic [PROD_W-1:0]   in_prod;
    logic [MIDX_W-1:0]   s0_qd;
    logic [MIDX_W-1:0]   s0_r;
    logic [MIDX_W-1:0]   s0_rc;
    logic [DMEM_AW-1:0]  s0_midx;
    logic [REG_AW-1:0]   s0_rs;
    logic [REG_AW-1:0]   s0_rt;

    logic [5:0]          ex_opc;
    logic [5:0]          ex_fn;
    logic [REG_AW-1:0]   ex_rs;
    logic [REG_AW-1:0]   ex_rt;
    logic [REG_AW-1:0]   ex_rd;
    logic [31:0]         ex_imm;
    logic [31:0]         ex_a;
    logic [31:0]         ex_b;
    logic [31:0]         ex_mword;
    logic                ex_wr;
    logic [REG_AW-1:0]   ex_widx;
    logic [31:0]         ex_wval;

    status_t             status_next;
    logic [31:0]         next_pc_next;
    logic                reg_written_next;
    logic                mem_written_next;
    logic                halted_next;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s0_adv = s0_valid_reg && (!s1_valid_reg || s1_adv);
    assign in_stall = clearing_reg || (s0_valid_reg && !s0_adv);
    assign in_accept = in_valid && !in_stall;

    // Address reduction, first half: offset and reciprocal multiply.
    assign in_v = MIDX_W'(instruction_word[15:2])
                + (instruction_word[15] ? MIDX_W'(NEG_OFS) : '0);
    assign in_prod = PROD_W'(in_v) * PROD_W'(RECIP);

    // Second half: subtract the quotient times the depth, then one correction.
    assign s0_qd = MIDX_W'(s0_q_reg) * DEPTH_M;
    assign s0_r = s0_v_reg - s0_qd;
    assign s0_rc = (s0_r >= DEPTH_M) ? (s0_r - DEPTH_M) : s0_r;
    assign s0_midx = s0_rc[DMEM_AW-1:0];
    assign s0_rs = s0_instr_reg[25:21];
    assign s0_rt = s0_instr_reg[20:16];

    assign ex_opc = s1_instr_reg[31:26];
    assign ex_fn = s1_instr_reg[5:0];
    assign ex_rs = s1_instr_reg[25:21];
    assign ex_rt = s1_instr_reg[20:16];
    assign ex_rd = s1_instr_reg[15:11];
    assign ex_imm = {{16{s1_instr_reg[15]}}, s1_instr_reg[15:0]};

    always_comb
    begin
        if (ex_rs == '0)
        begin
            ex_a = '0;
        end
        else if (fwd_rf_valid_reg && fwd_rf_idx_reg == ex_rs)
        begin
            ex_a = fwd_rf_val_reg;
        end
        else
        begin
            ex_a = rs_vld_reg ? rs_data_reg : '0;
        end

        if (ex_rt == '0)
        begin
            ex_b = '0;
        end
        else if (fwd_rf_valid_reg && fwd_rf_idx_reg == ex_rt)
        begin
            ex_b = fwd_rf_val_reg;
        end
        else
        begin
            ex_b = rt_vld_reg ? rt_data_reg : '0;
        end

        if (fwd_mem_valid_reg && fwd_mem_idx_reg == s1_midx_reg)
        begin
            ex_mword = fwd_mem_val_reg;
        end
        else
        begin
            ex_mword = dmem_rd_reg;
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        next_pc_next = pc_reg + 32'd4;
        ex_wr = 1'b0;
        ex_widx = '0;
        ex_wval = '0;
        mem_written_next = 1'b0;
        halted_next = halted_reg;

        if (halted_reg)
        begin
            status_next = ST_END;
            next_pc_next = pc_reg;
        end
        else
        begin
            unique case (ex_opc) inside
                OPC_SPECIAL:
                begin
                    unique case (ex_fn)
                        FN_NOP:
                        begin
                            ex_wr = 1'b0;
                        end
                        FN_ADDU:
                        begin
                            ex_wr = 1'b1;
                            ex_widx = ex_rd;
                            ex_wval = ex_a + ex_b;
                        end
                        FN_SLT:
                        begin
                            ex_wr = 1'b1;
                            ex_widx = ex_rd;
                            ex_wval = {31'd0, ($signed(ex_a) < $signed(ex_b))};
                        end
                        default:
                        begin
                            status_next = ST_NOT_IMPL;
                        end
                    endcase
                end
                OPC_BEQ, OPC_BNE:
                begin
                    if ((ex_a == ex_b) == (ex_opc == OPC_BEQ))
                    begin
                        next_pc_next = pc_reg + 32'd4 + {ex_imm[29:0], 2'b00};
                    end
                end
                OPC_ADDIU:
                begin
                    ex_wr = 1'b1;
                    ex_widx = ex_rt;
                    ex_wval = ex_a + ex_imm;
                end
                OPC_LW:
                begin
                    ex_wr = 1'b1;
                    ex_widx = ex_rt;
                    ex_wval = ex_mword;
                end
                OPC_SW:
                begin
                    mem_written_next = 1'b1;
                end
                OPC_END:
                begin
                    status_next = ST_END;
                    next_pc_next = pc_reg;
                    halted_next = 1'b1;
                end
                default:
                begin
                    status_next = ST_NOT_IMPL;
                end
            endcase
        end

        reg_written_next = ex_wr && (ex_widx != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            rf_valid_reg <= '0;
            fwd_rf_valid_reg <= 1'b0;
            fwd_mem_valid_reg <= 1'b0;
            pc_reg <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == DMEM_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (in_accept)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (s0_adv)
            begin
                s0_valid_reg <= 1'b0;
            end

            if (s0_adv)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                fwd_rf_valid_reg <= reg_written_next;
                fwd_mem_valid_reg <= mem_written_next;
                pc_reg <= next_pc_next;
                halted_reg <= halted_next;
                if (reg_written_next)
                begin
                    rf_valid_reg[ex_widx] <= 1'b1;
                end
            end
            else if (cfg_wr_en)
            begin
                pc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_instr_reg <= instruction_word;
            s0_v_reg <= in_v;
            s0_q_reg <= in_prod[PROD_W-1:MIDX_W];
        end

        if (s0_adv)
        begin
            s1_instr_reg <= s0_instr_reg;
            s1_midx_reg <= s0_midx;
            rs_vld_reg <= rf_valid_reg[s0_rs];
            rt_vld_reg <= rf_valid_reg[s0_rt];
        end

        if (s1_adv)
        begin
            fwd_rf_idx_reg <= ex_widx;
            fwd_rf_val_reg <= ex_wval;
            fwd_mem_idx_reg <= s1_midx_reg;
            fwd_mem_val_reg <= ex_b;
            status_reg <= status_next;
            next_pc_reg <= next_pc_next;
            reg_written_reg <= reg_written_next;
            reg_index_reg <= reg_written_next ? ex_widx : '0;
            reg_value_reg <= reg_written_next ? ex_wval : '0;
            mem_written_reg <= mem_written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && reg_written_next)
        begin
            rf_mem[ex_widx] <= ex_wval;
        end
        if (s0_adv)
        begin
            rs_data_reg <= rf_mem[s0_rs];
            rt_data_reg <= rf_mem[s0_rt];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            dmem_mem[clr_addr_reg] <= '0;
        end
        else if (s1_adv && mem_written_next)
        begin
            dmem_mem[s1_midx_reg] <= ex_b;
        end
        if (s0_adv)
        begin
            dmem_rd_reg <= dmem_mem[s0_midx];
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign next_pc = next_pc_reg;
    assign reg_written = reg_written_reg;
    assign reg_index = reg_index_reg;
    assign reg_value = reg_value_reg;
    assign mem_written = mem_written_reg;

endmodule
